// ===== rtl/iq_background_ewma_subtract_top_defines.svh =====
// Assertion macros for the I/Q background subtraction block.
// Included by the top module, which carries the concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef IQ_BACKGROUND_EWMA_SUBTRACT_TOP_DEFINES_SVH
`define IQ_BACKGROUND_EWMA_SUBTRACT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define IQBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define IQBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IQBG_ASSERT(lbl, prop, msg)
`define IQBG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/iqbg_pkg.sv =====
// Shared types and constants for the I/Q background subtraction block.
// No dependencies; used by the configuration, lane and top files of the block.
`timescale 1ns / 1ps

package iqbg_pkg;

  localparam int unsigned BIN_COUNT = 4096;
  localparam int unsigned BIN_W     = $clog2(BIN_COUNT);
  localparam int unsigned FILL_W    = $clog2(BIN_COUNT + 1);

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned BG_W      = 24;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Q15 unity and the matching shift of the running average.
  localparam logic [WEIGHT_W:0] Q15_ONE = 17'd32768;
  localparam int unsigned Q15_SHIFT = 15;

  localparam logic [WEIGHT_W-1:0] ALPHA_RESET = 16'd31744;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BIN_COUNT);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_WEIGHT = 2'd0,
    REG_LEARN_ONLY   = 2'd1,
    REG_BYPASS       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] alpha_weight;
    logic                learn_only_mode;
    logic                bypass_mode;
  } cfg_t;

endpackage

// ===== rtl/iqbg_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies; holds the per-bin background of the block.
`timescale 1ns / 1ps

module iqbg_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/iqbg_cfg.sv =====
// Configuration register file: weight of the old background and the two mode bits.
// Depends on iqbg_pkg for the register indices and the configuration struct.
`timescale 1ns / 1ps

module iqbg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iqbg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [iqbg_pkg::WEIGHT_W-1:0]   cfg_data_i,
  output iqbg_pkg::cfg_t                  cfg_o
);

  iqbg_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken; an index beyond the register list is ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (iqbg_pkg::cfg_reg_e'(cfg_index_i))
        iqbg_pkg::REG_ALPHA_WEIGHT: cfg_d.alpha_weight    = cfg_data_i;
        iqbg_pkg::REG_LEARN_ONLY:   cfg_d.learn_only_mode = cfg_data_i[0];
        iqbg_pkg::REG_BYPASS:       cfg_d.bypass_mode     = cfg_data_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_weight    <= iqbg_pkg::ALPHA_RESET;
      cfg_q.learn_only_mode <= 1'b0;
      cfg_q.bypass_mode     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/iqbg_lane.sv =====
// One channel (I or Q) of the datapath: running-average update and background removal.
// Depends on iqbg_pkg for widths, the Q15 constants and the configuration struct.
`timescale 1ns / 1ps

module iqbg_lane (
  input  logic signed [iqbg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [iqbg_pkg::BG_W-1:0]     old_bg_i,
  input  iqbg_pkg::cfg_t                       cfg_i,
  output logic signed [iqbg_pkg::BG_W-1:0]     new_bg_o,
  output logic signed [iqbg_pkg::SAMPLE_W-1:0] result_o
);

  logic [iqbg_pkg::WEIGHT_W-1:0] w_new;
  logic signed [40:0]            p_old;
  logic signed [32:0]            p_smp;
  logic signed [41:0]            sum;
  logic signed [24:0]            diff;
  logic signed [15:0]            diff_sat;

  // The weight of the sample wraps to 16 bits when alpha exceeds unity.
  assign w_new = iqbg_pkg::WEIGHT_W'(iqbg_pkg::Q15_ONE - {1'b0, cfg_i.alpha_weight});

  assign p_old = $signed({1'b0, cfg_i.alpha_weight}) * old_bg_i;
  assign p_smp = $signed({1'b0, w_new}) * sample_i;
  assign sum   = {p_old[40], p_old} + {{9{p_smp[32]}}, p_smp};

  // Arithmetic shift by 15 and keep the low 24 bits of the result.
  assign new_bg_o = sum[iqbg_pkg::Q15_SHIFT + iqbg_pkg::BG_W - 1:iqbg_pkg::Q15_SHIFT];

  assign diff = {{9{sample_i[15]}}, sample_i} - {old_bg_i[23], old_bg_i};

  always_comb begin
    if (diff[24:15] == '0 || diff[24:15] == '1) begin
      diff_sat = diff[15:0];
    end else if (diff[24]) begin
      diff_sat = 16'sh8000;
    end else begin
      diff_sat = 16'sh7FFF;
    end
  end

  always_comb begin
    priority if (cfg_i.bypass_mode) begin
      result_o = sample_i;
    end else if (cfg_i.learn_only_mode) begin
      result_o = '0;
    end else begin
      result_o = diff_sat;
    end
  end

endmodule

// ===== rtl/iq_background_ewma_subtract_top.sv =====
// Pipeline: an accepted transaction passes the input register, then the result register;
// an output stall holds it in the input register. Throughput: one transaction per cycle
// unless the output stalls; the read-modify-write of a bin's background in the RAM is spread
// over the input and result stages, with forwarding of the last write.
// Reset: clears the bin index, the pipeline and the configuration at once; the background
// needs no clearing pass, as a fill count marks the bins never written, which read as zero.
`timescale 1ns / 1ps
`include "iq_background_ewma_subtract_top_defines.svh"

module iq_background_ewma_subtract_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [iqbg_pkg::SAMPLE_W-1:0] i_sample_i,
  input  logic signed [iqbg_pkg::SAMPLE_W-1:0] q_sample_i,
  input  logic                                 sweep_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [iqbg_pkg::SAMPLE_W-1:0] i_result_o,
  output logic signed [iqbg_pkg::SAMPLE_W-1:0] q_result_o,
  output logic                                 result_end_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [iqbg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [iqbg_pkg::WEIGHT_W-1:0]        cfg_data_i
);

  localparam int unsigned BinW  = iqbg_pkg::BIN_W;
  localparam int unsigned FillW = iqbg_pkg::FILL_W;
  localparam int unsigned BgW   = iqbg_pkg::BG_W;
  localparam int unsigned SmpW  = iqbg_pkg::SAMPLE_W;

  iqbg_pkg::cfg_t cfg;

  logic in_accept;
  logic b_adv;
  logic ram_we;

  logic [BinW-1:0]  bin_q, bin_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] bin_ext;
  logic             seen;

  logic                   s1_valid_q, s1_valid_d;
  logic signed [SmpW-1:0] s1_i_q, s1_q_q;
  logic                   s1_end_q;
  logic [BinW-1:0]        s1_bin_q;
  logic                   s1_seen_q;

  logic                 wb_valid_q;
  logic [BinW-1:0]      wb_bin_q;
  logic [2*BgW-1:0]     wb_data_q;
  logic                 fwd_hit;
  logic [2*BgW-1:0]     rd_data;
  logic [2*BgW-1:0]     old_bg;
  logic signed [BgW-1:0] new_i, new_q;
  logic signed [SmpW-1:0] res_i, res_q;

  logic                   out_valid_q;
  logic signed [SmpW-1:0] out_i_q, out_q_q;
  logic                   out_end_q;

  iqbg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the result stage frees the input stage, which frees the input.
  assign b_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !b_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ram_we     = s1_valid_q && b_adv;

  // Bins are visited in order from zero, so the written bins are always a prefix.
  assign bin_ext = FillW'(bin_q);
  assign seen    = bin_ext < fill_q;

  always_comb begin
    bin_d  = bin_q;
    fill_d = fill_q;
    if (in_accept) begin
      if (sweep_end_i || bin_q == iqbg_pkg::LAST_BIN) begin
        bin_d = '0;
      end else begin
        bin_d = bin_q + 1'b1;
      end
      if (!seen) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (b_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bin_q      <= bin_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
      if (ram_we) begin
        wb_valid_q <= 1'b1;
      end
      if (b_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_i_q    <= i_sample_i;
      s1_q_q    <= q_sample_i;
      s1_end_q  <= sweep_end_i;
      s1_bin_q  <= bin_q;
      s1_seen_q <= seen;
    end
    if (ram_we) begin
      wb_bin_q  <= s1_bin_q;
      wb_data_q <= {new_i, new_q};
    end
    if (ram_we) begin
      out_i_q   <= res_i;
      out_q_q   <= res_q;
      out_end_q <= s1_end_q;
    end
  end

  iqbg_ram #(
    .DEPTH (iqbg_pkg::BIN_COUNT),
    .WIDTH (2 * BgW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_bin_q),
    .wdata_i ({new_i, new_q}),
    .re_i    (in_accept),
    .raddr_i (bin_q),
    .rdata_o (rd_data)
  );

  // The write of the preceding transaction can land on the edge of this read, so the last
  // written value takes precedence over the RAM when the bins match.
  assign fwd_hit = wb_valid_q && (wb_bin_q == s1_bin_q);

  always_comb begin
    priority if (fwd_hit) begin
      old_bg = wb_data_q;
    end else if (s1_seen_q) begin
      old_bg = rd_data;
    end else begin
      old_bg = '0;
    end
  end

  iqbg_lane u_lane_i (
    .sample_i (s1_i_q),
    .old_bg_i (old_bg[2*BgW-1:BgW]),
    .cfg_i    (cfg),
    .new_bg_o (new_i),
    .result_o (res_i)
  );

  iqbg_lane u_lane_q (
    .sample_i (s1_q_q),
    .old_bg_i (old_bg[BgW-1:0]),
    .cfg_i    (cfg),
    .new_bg_o (new_q),
    .result_o (res_q)
  );

  assign out_valid_o  = out_valid_q;
  assign i_result_o   = out_i_q;
  assign q_result_o   = out_q_q;
  assign result_end_o = out_end_q;

  `IQBG_ASSERT(bin_within_fill_a, bin_ext <= fill_q, "bin index ran past the written bins")
  `IQBG_ASSERT(fill_bounded_a, fill_q <= iqbg_pkg::FILL_MAX, "fill count beyond bin count")
  `IQBG_ASSERT_NEXT(sweep_end_rewinds_a, in_accept && sweep_end_i, bin_q == '0, "no rewind")
  `IQBG_ASSERT_NEXT(write_gives_result_a, ram_we, out_valid_o, "update without a result")
  `IQBG_ASSERT_NEXT(bypass_passes_a, ram_we && cfg.bypass_mode,
                    i_result_o == $past(s1_i_q) && q_result_o == $past(s1_q_q),
                    "bypass altered the sample")

endmodule
